@@ hdl/kmds_pkg.sv @@
// Package for the key matrix debounce scanner: matrix size, widths, reset
// value of the debounce register and the channel word types.
// No dependencies.
`default_nettype none

package kmds_pkg;

    localparam int ROWS      = 8;
    localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ROW_W     = 3;
    localparam int LVL_W     = 8;
    localparam int COL_W     = 7;
    localparam int STB_W     = 8;
    localparam int CNT_W     = 8;

    localparam logic [CNT_W-1:0] DEBOUNCE_RESET = CNT_W'(5);
    localparam logic [ROW_W-1:0] LAST_ROW       = ROW_W'(ROWS - 1);

    typedef logic [COL_W-1:0] t_cols;
    typedef logic [CNT_W-1:0] t_count;

    typedef struct packed {
        logic [ROW_W-1:0] row_index;
        logic [LVL_W-1:0] channel_levels;
    } t_in_word;

    typedef struct packed {
        logic [COL_W-1:0] packed_cols;
        logic [STB_W-1:0] stable_row;
        logic             committed;
        logic             bouncing;
    } t_out_word;

endpackage

`default_nettype wire

@@ hdl/kmds_in_if.sv @@
// Channel interface for sampled row words into the scanner.
// Depends on kmds_pkg.
`default_nettype none

interface kmds_in_if;
    logic                valid;
    logic                ready;
    kmds_pkg::t_in_word  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hdl/kmds_out_if.sv @@
// Channel interface for result words from the scanner.
// Depends on kmds_pkg.
`default_nettype none

interface kmds_out_if;
    logic                valid;
    logic                ready;
    kmds_pkg::t_out_word payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hdl/kmds_cfg_if.sv @@
// Write channel for the debounce pass count register.
// Depends on kmds_pkg.
`default_nettype none

interface kmds_cfg_if;
    logic                  valid;
    logic                  ready;
    kmds_pkg::t_count      data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/key_matrix_debounce_scanner.sv @@
// Key matrix scanner with one shared debounce countdown.
// Path: an accepted word is registered in the input register, and its result word
//   is registered in the result register once the output can take it.
// Throughput: one word per cycle while the output is ready; the input and result registers decouple.
// Reset (synchronous, active low): pending and stable matrices cleared,
//   countdown and debounce register set to 5, both channels empty.
// Depends on kmds_pkg, kmds_in_if, kmds_out_if, kmds_cfg_if.
`default_nettype none

module key_matrix_debounce_scanner (
    input  wire  i_clk,
    input  wire  i_rst_n,
    kmds_in_if.sink    i_in,
    kmds_cfg_if.sink   i_cfg,
    kmds_out_if.source o_out
);
    import kmds_pkg::*;

    logic                r_in_valid;
    t_in_word            r_in;
    logic                r_out_valid;
    t_out_word           r_out;
    t_count              r_debounce;
    t_count              r_count;
    t_cols               r_pending [ROWS];
    t_cols               r_stable  [ROWS];

    t_count              n_count;
    t_cols               n_pending [ROWS];
    t_cols               n_stable  [ROWS];
    t_out_word           n_out;

    logic                advance;
    logic                in_range;
    logic [ROW_IDX_W-1:0] row_sel;
    logic [LVL_W-1:0]    word;
    t_cols               cols;
    t_count              loaded;
    logic                dec;
    logic                commit;

    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.payload = r_out;

    always_comb begin
        word = '0;
        for (int j = 0; j < ROWS; j++) begin
            if (j < int'(r_in.row_index)) begin
                word[j] = r_in.channel_levels[j];
            end else if (j > int'(r_in.row_index)) begin
                word[j-1] = r_in.channel_levels[j];
            end
        end
        cols = word[COL_W-1:0];
    end

    assign in_range = int'(r_in.row_index) < ROWS;
    assign row_sel  = r_in.row_index[ROW_IDX_W-1:0];

    always_comb begin
        n_pending = r_pending;
        n_stable  = r_stable;
        n_count   = r_count;
        loaded    = r_count;
        dec       = 1'b0;
        commit    = 1'b0;
        if (in_range) begin
            if (r_pending[row_sel] != cols) begin
                n_pending[row_sel] = cols;
                loaded = r_debounce;
            end
            dec     = (r_in.row_index == LAST_ROW) && (loaded != '0);
            commit  = dec && (loaded == t_count'(1));
            n_count = dec ? loaded - t_count'(1) : loaded;
            if (commit) begin
                n_stable = n_pending;
            end
        end
        n_out.packed_cols = cols;
        n_out.stable_row  = in_range ? STB_W'(n_stable[row_sel]) : '0;
        n_out.committed   = commit;
        n_out.bouncing    = (n_count != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_debounce  <= DEBOUNCE_RESET;
            r_count     <= DEBOUNCE_RESET;
            for (int k = 0; k < ROWS; k++) begin
                r_pending[k] <= '0;
                r_stable[k]  <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                r_debounce <= i_cfg.data;
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
                r_pending   <= n_pending;
                r_stable    <= n_stable;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in <= i_in.payload;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire
